// ===== hw/rtl/tical_pkg.sv =====
// Shared types and constants of the temperature-interpolated calibration table.
`timescale 1ns / 1ps
`default_nettype none
package tical_pkg;

    // Command codes carried in the input tuser field
    typedef enum logic [2:0] {
        CMD_UPD_TEMP   = 3'd0,
        CMD_FORCE_TEMP = 3'd1,
        CMD_WR_POINT   = 3'd2,
        CMD_RD_ACTIVE  = 3'd3,
        CMD_RD_POINT   = 3'd4,
        CMD_CLR_DIRTY  = 3'd5
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] REG_PT_LOW  = 2'd0;
    localparam logic [1:0] REG_PT_MID  = 2'd1;
    localparam logic [1:0] REG_PT_HIGH = 2'd2;
    localparam logic [1:0] REG_HYST    = 2'd3;

    // Q8 weight format
    localparam int         FRAC_BITS = 8;
    localparam logic [8:0] Q8_ONE    = 9'd256;

    // Reset values
    localparam logic signed [15:0] RST_PT_LOW      = 16'sd50;
    localparam logic signed [15:0] RST_PT_MID      = 16'sd250;
    localparam logic signed [15:0] RST_PT_HIGH     = 16'sd450;
    localparam logic        [14:0] RST_HYST        = 15'd20;
    localparam logic signed [15:0] RST_ACTIVE_TEMP = 16'sd250;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_RAW,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_LERP,
        ST_D_CMP,
        ST_D_SUB,
        ST_D_DIV,
        ST_OUT
    } t_state;

    // Status flags of one result word, dirty in the lowest bit
    typedef struct packed {
        logic index_error;
        logic temp_changed;
        logic dirty;
    } t_flags;

endpackage
`default_nettype wire

// ===== hw/rtl/tical_store.sv =====
// Reference value memory with per-entry valid bits so unwritten entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module tical_store #(
    parameter int DEPTH = 132,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);
    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 16'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/tical_div.sv =====
// Restoring divider that produces the Q8 interpolation weight one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tical_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_busy,
    output logic [tical_pkg::FRAC_BITS-1:0] o_quot
);
    import tical_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [CW-1:0]        r_cnt;
    logic [16:0]          r_rem;
    logic [15:0]          r_den;
    logic [FRAC_BITS-1:0] r_quot;
    logic [16:0]          rem_sh;
    logic [16:0]          rem_sub;
    logic                 fits;

    // Numerator stays below the divisor, so the shifted remainder fits 17 bits
    assign rem_sh  = {r_rem[15:0], 1'b0};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(FRAC_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? rem_sub : rem_sh;
            r_quot <= {r_quot[FRAC_BITS-2:0], fits};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== hw/rtl/temp_interpolated_cal_table.sv =====
// Top level: command sequencer, temperature tracking and interpolation datapath.
// Write, clear and unused commands run the execute and output states; a raw point read adds a
// store read, an active read two reads, multiply and lerp, a temperature load the 8-step divider.
// One word at a time: the next word is accepted back in idle, after the result word has loaded.
// A temperature point register write reruns the weight derivation, with tready low meanwhile.
// Reset (synchronous, active low) clears the store valid bits and then derives the weight.
`timescale 1ns / 1ps
`default_nettype none
module temp_interpolated_cal_table #(
    parameter int TEMP_POINTS = 3,
    parameter int TABLE_COUNT = 4,
    parameter int SOC_POINTS  = 11
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] temperature, [17:16] temp_index, [19:18] table_select, [23:20] soc_index,
    // [39:24] write_value
    input  wire logic [39:0] s_axis_tdata,
    // [2:0] command
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] read_value, [31:16] current_temp
    output logic [31:0]      m_axis_tdata,
    // [0] dirty, [1] temp_changed, [2] index_error
    output logic [2:0]       m_axis_tuser
);
    import tical_pkg::*;

    localparam int DEPTH = TABLE_COUNT * TEMP_POINTS * SOC_POINTS;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic signed [15:0] r_pt [3];
    logic        [14:0] r_hyst;
    logic signed [15:0] r_active;
    logic               r_interval;
    logic        [8:0]  r_weight;
    logic               r_dirty;
    logic               r_derive_pend;
    logic               r_from_cmd;
    logic               r_m_valid;

    logic        [2:0]  r_cmd;
    logic signed [15:0] r_temp;
    logic        [1:0]  r_ti;
    logic        [1:0]  r_tbl;
    logic        [3:0]  r_idx;
    logic        [15:0] r_wval;
    logic      [AW-1:0] r_addr;
    logic        [15:0] r_a;
    logic        [15:0] r_b;
    logic signed [26:0] r_prod;
    logic        [15:0] r_rd;
    logic               r_changed;
    logic               r_err;
    logic        [31:0] r_m_data;
    t_flags             r_m_user;

    logic               accept;
    logic               act_ok;
    logic               pt_ok;
    logic        [1:0]  ti_sel;
    logic      [AW-1:0] addr_calc;
    logic signed [16:0] temp_diff;
    logic        [16:0] temp_mag;
    logic               hyst_ok;
    logic signed [15:0] pt_last;
    logic               t_le_first;
    logic               t_ge_last;
    logic               lo_up;
    logic signed [15:0] p_lo;
    logic signed [15:0] p_hi;
    logic signed [16:0] num_full;
    logic signed [16:0] den_full;
    logic signed [16:0] lerp_diff;
    logic signed [9:0]  w_s;
    logic signed [18:0] lerp_q;
    logic        [19:0] lerp_sum;
    logic        [15:0] lerp_val;

    logic               mem_we;
    logic               mem_re;
    logic      [AW-1:0] mem_raddr;
    logic        [15:0] mem_rdata;
    logic               div_start;
    logic               div_busy;
    logic [FRAC_BITS-1:0] div_quot;
    logic               out_load;

    tical_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (addr_calc),
        .i_wdata (r_wval),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tical_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_full[15:0]),
        .i_den   (den_full[15:0]),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign accept = s_axis_tvalid && s_axis_tready;

    // Index checks and store address
    assign act_ok    = (32'(r_tbl) < TABLE_COUNT) && (32'(r_idx) < SOC_POINTS);
    assign pt_ok     = act_ok && (32'(r_ti) < TEMP_POINTS);
    assign ti_sel    = (r_cmd == CMD_RD_ACTIVE) ? {1'b0, r_interval} : r_ti;
    assign addr_calc = AW'((32'(r_tbl) * TEMP_POINTS + 32'(ti_sel)) * SOC_POINTS
                           + 32'(r_idx));

    // Hysteresis check
    assign temp_diff = {r_temp[15], r_temp} - {r_active[15], r_active};
    assign temp_mag  = temp_diff[16] ? 17'(-temp_diff) : 17'(temp_diff);
    assign hyst_ok   = temp_mag >= {2'b00, r_hyst};

    // Interval search against the calibration points
    assign pt_last    = r_pt[2'(TEMP_POINTS - 1)];
    assign t_le_first = r_active <= r_pt[0];
    assign t_ge_last  = r_active >= pt_last;
    assign lo_up      = (TEMP_POINTS == 3) && (r_active >= r_pt[1]);
    assign p_lo       = r_interval ? r_pt[1] : r_pt[0];
    assign p_hi       = r_interval ? r_pt[2] : r_pt[1];
    assign num_full   = {r_active[15], r_active} - {p_lo[15], p_lo};
    assign den_full   = {p_hi[15], p_hi} - {p_lo[15], p_lo};

    // Lerp: floor shift of the product, then clamp to the 16-bit range
    assign lerp_diff = $signed({1'b0, r_b}) - $signed({1'b0, r_a});
    assign w_s       = $signed({1'b0, r_weight});
    assign lerp_q    = r_prod[26:FRAC_BITS];
    assign lerp_sum  = {4'b0000, r_a} + {lerp_q[18], lerp_q};
    always_comb begin
        if (lerp_sum[19]) begin
            lerp_val = 16'd0;
        end else if (lerp_sum[18:16] != 3'd0) begin
            lerp_val = 16'hFFFF;
        end else begin
            lerp_val = lerp_sum[15:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (r_derive_pend) begin
                    n_state = ST_D_CMP;
                end else if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_UPD_TEMP:   n_state = hyst_ok ? ST_D_CMP : ST_OUT;
                    CMD_FORCE_TEMP: n_state = ST_D_CMP;
                    CMD_RD_ACTIVE:  n_state = act_ok ? ST_RD_A : ST_OUT;
                    CMD_RD_POINT:   n_state = pt_ok ? ST_RD_RAW : ST_OUT;
                    default:        n_state = ST_OUT;
                endcase
            end
            ST_RD_RAW: n_state = ST_OUT;
            ST_RD_A:   n_state = ST_RD_B;
            ST_RD_B:   n_state = ST_MUL;
            ST_MUL:    n_state = ST_LERP;
            ST_LERP:   n_state = ST_OUT;
            ST_D_CMP: begin
                if (t_le_first || t_ge_last) begin
                    n_state = r_from_cmd ? ST_OUT : ST_IDLE;
                end else begin
                    n_state = ST_D_SUB;
                end
            end
            ST_D_SUB: n_state = ST_D_DIV;
            ST_D_DIV: begin
                if (!div_busy) begin
                    n_state = r_from_cmd ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = addr_calc;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = !r_derive_pend;
            ST_EXEC: begin
                mem_we = (r_cmd == CMD_WR_POINT) && pt_ok;
                mem_re = ((r_cmd == CMD_RD_POINT) && pt_ok)
                      || ((r_cmd == CMD_RD_ACTIVE) && act_ok);
            end
            ST_RD_A: begin
                // upper temperature point sits one SOC row further on
                mem_re    = 1'b1;
                mem_raddr = r_addr + AW'(SOC_POINTS);
            end
            ST_D_SUB: div_start = 1'b1;
            ST_OUT:   out_load  = !r_m_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pt[0]       <= RST_PT_LOW;
            r_pt[1]       <= RST_PT_MID;
            r_pt[2]       <= RST_PT_HIGH;
            r_hyst        <= RST_HYST;
            r_active      <= RST_ACTIVE_TEMP;
            r_interval    <= 1'b0;
            r_weight      <= '0;
            r_dirty       <= 1'b0;
            r_derive_pend <= 1'b1;
            r_from_cmd    <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PT_LOW:  r_pt[0] <= $signed(i_cfg_wdata);
                    REG_PT_MID:  r_pt[1] <= $signed(i_cfg_wdata);
                    REG_PT_HIGH: r_pt[2] <= $signed(i_cfg_wdata);
                    REG_HYST:    r_hyst  <= i_cfg_wdata[14:0];
                    default:     r_hyst  <= r_hyst;
                endcase
            end

            // A point write during a derivation pass queues another pass
            if (i_cfg_we && (i_cfg_addr != REG_HYST)) begin
                r_derive_pend <= 1'b1;
            end else if ((r_state == ST_IDLE) && r_derive_pend) begin
                r_derive_pend <= 1'b0;
            end

            case (r_state)
                ST_IDLE: r_from_cmd <= !r_derive_pend;
                ST_EXEC: begin
                    case (r_cmd)
                        CMD_UPD_TEMP: begin
                            if (hyst_ok) begin
                                r_active <= r_temp;
                            end
                        end
                        CMD_FORCE_TEMP: r_active <= r_temp;
                        CMD_WR_POINT: begin
                            if (pt_ok) begin
                                r_dirty <= 1'b1;
                            end
                        end
                        CMD_CLR_DIRTY: r_dirty <= 1'b0;
                        default: r_dirty <= r_dirty;
                    endcase
                end
                ST_D_CMP: begin
                    if (t_le_first) begin
                        r_interval <= 1'b0;
                        r_weight   <= '0;
                    end else if (t_ge_last) begin
                        r_interval <= 1'(TEMP_POINTS - 2);
                        r_weight   <= Q8_ONE;
                    end else begin
                        r_interval <= lo_up;
                    end
                end
                ST_D_DIV: begin
                    if (!div_busy) begin
                        r_weight <= {1'b0, div_quot};
                    end
                end
                default: r_from_cmd <= r_from_cmd;
            endcase

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Item payload and datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= s_axis_tuser;
            r_temp    <= $signed(s_axis_tdata[15:0]);
            r_ti      <= s_axis_tdata[17:16];
            r_tbl     <= s_axis_tdata[19:18];
            r_idx     <= s_axis_tdata[23:20];
            r_wval    <= s_axis_tdata[39:24];
            r_rd      <= 16'd0;
        end
        case (r_state)
            ST_EXEC: begin
                r_addr    <= addr_calc;
                r_changed <= ((r_cmd == CMD_UPD_TEMP) && hyst_ok)
                          || (r_cmd == CMD_FORCE_TEMP);
                r_err     <= (((r_cmd == CMD_WR_POINT) || (r_cmd == CMD_RD_POINT)) && !pt_ok)
                          || ((r_cmd == CMD_RD_ACTIVE) && !act_ok);
            end
            ST_RD_RAW: r_rd   <= mem_rdata;
            ST_RD_A:   r_a    <= mem_rdata;
            ST_RD_B:   r_b    <= mem_rdata;
            ST_MUL:    r_prod <= lerp_diff * w_s;
            ST_LERP:   r_rd   <= lerp_val;
            default:   r_a    <= r_a;
        endcase
        if (out_load) begin
            r_m_data              <= {r_active, r_rd};
            r_m_user.index_error  <= r_err;
            r_m_user.temp_changed <= r_changed;
            r_m_user.dirty        <= r_dirty;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_busy)
        else $error("input ready while the weight divider is running");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_div_weight_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_D_DIV) && !div_busy) |=> !r_weight[8])
        else $error("divided weight reached one");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result word raised outside the output state");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the temperature-interpolated calibration table.
module tb;
    import tical_pkg::*;

    localparam int TEMP_POINTS = 3;
    localparam int TABLE_COUNT = 4;
    localparam int SOC_POINTS  = 11;
    localparam int CAL_DEPTH   = TABLE_COUNT * TEMP_POINTS * SOC_POINTS;
    localparam int SETTLE      = 16;      // longest command plus margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 145;

    // Command codes the block decodes as no-ops
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [15:0] read_value;
        logic [15:0] current_temp;
        t_flags      flags;
    } t_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    temp_interpolated_cal_table #(
        .TEMP_POINTS(TEMP_POINTS),
        .TABLE_COUNT(TABLE_COUNT),
        .SOC_POINTS (SOC_POINTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial forever #6 i_clk = ~i_clk;

    // Shadow state of the table
    logic [15:0] cal_mem [CAL_DEPTH];
    int          pt [TEMP_POINTS];
    int          hyst;
    int          act_temp;
    int          seg;
    int          wgt;
    logic        dirty_q;

    t_result     pending_results [$];
    int          errors       = 0;
    int          sent_count   = 0;
    int          result_count = 0;
    int          cfg_count    = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;
    bit          steady       = 1'b0;
    logic [15:0] rx_pattern   = 16'hFFFF;
    int          rx_hold      = 0;

    function automatic int cal_addr(int tbl, int ti, int soc);
        return (tbl * TEMP_POINTS + ti) * SOC_POINTS + soc;
    endfunction

    function automatic void derive_weight();
        int span;
        if (act_temp <= pt[0]) begin
            seg = 0;
            wgt = 0;
        end else if (act_temp >= pt[TEMP_POINTS-1]) begin
            seg = TEMP_POINTS - 2;
            wgt = int'(Q8_ONE);
        end else begin
            seg = 0;
            for (int k = 0; k + 2 < TEMP_POINTS; k++) begin
                if (act_temp < pt[k+1]) break;
                seg = k + 1;
            end
            span = pt[seg+1] - pt[seg];
            wgt  = (span > 0) ? ((act_temp - pt[seg]) * int'(Q8_ONE)) / span : 0;
        end
    endfunction

    function automatic void reset_model();
        foreach (cal_mem[i]) cal_mem[i] = '0;
        pt[0]    = RST_PT_LOW;
        pt[1]    = RST_PT_MID;
        pt[2]    = RST_PT_HIGH;
        hyst     = RST_HYST;
        act_temp = RST_ACTIVE_TEMP;
        dirty_q  = 1'b0;
        derive_weight();
    endfunction

    // Apply one command to the shadow state and return the word it yields
    function automatic t_result predict_command(logic [2:0] cmd, logic [15:0] temp,
                                                logic [1:0] ti, logic [1:0] tbl,
                                                logic [3:0] soc, logic [15:0] wv);
        t_result r;
        int      t, d, a, b, v, lo;
        bit      row_ok, point_ok;
        r        = '0;
        t        = $signed(temp);
        row_ok   = (tbl < TABLE_COUNT) && (soc < SOC_POINTS);
        point_ok = row_ok && (ti < TEMP_POINTS);
        case (cmd)
            CMD_UPD_TEMP: begin
                d = t - act_temp;
                if (d < 0) d = -d;
                if (d >= hyst) begin
                    act_temp = t;
                    derive_weight();
                    r.flags.temp_changed = 1'b1;
                end
            end
            CMD_FORCE_TEMP: begin
                act_temp = t;
                derive_weight();
                r.flags.temp_changed = 1'b1;
            end
            CMD_WR_POINT: begin
                if (point_ok) begin
                    cal_mem[cal_addr(tbl, ti, soc)] = wv;
                    dirty_q = 1'b1;
                end else begin
                    r.flags.index_error = 1'b1;
                end
            end
            CMD_RD_ACTIVE: begin
                if (row_ok) begin
                    lo = (seg > TEMP_POINTS - 2) ? TEMP_POINTS - 2 : seg;
                    a  = cal_mem[cal_addr(tbl, lo, soc)];
                    b  = cal_mem[cal_addr(tbl, lo + 1, soc)];
                    d  = (b - a) * wgt;
                    // arithmetic shift floors toward minus infinity
                    v  = a + (d >>> FRAC_BITS);
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    r.read_value = v[15:0];
                end else begin
                    r.flags.index_error = 1'b1;
                end
            end
            CMD_RD_POINT: begin
                if (point_ok) r.read_value = cal_mem[cal_addr(tbl, ti, soc)];
                else r.flags.index_error = 1'b1;
            end
            CMD_CLR_DIRTY: dirty_q = 1'b0;
            default: ;
        endcase
        r.current_temp = act_temp[15:0];
        r.flags.dirty  = dirty_q;
        return r;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Send one word in bursts with random gaps, then record what it should yield
    task automatic send_command(input logic [2:0] cmd, input logic [15:0] temp,
                                input logic [1:0] ti, input logic [1:0] tbl,
                                input logic [3:0] soc, input logic [15:0] wv);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) steady = !steady;
            gap        = steady ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wv, soc, tbl, ti, temp};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_command(cmd, temp, ti, tbl, soc, wv));
        sent_count++;
    endtask

    task automatic random_command();
        logic [2:0]  cmd;
        logic [15:0] temp, wv;
        logic [1:0]  ti, tbl;
        logic [3:0]  soc;
        int          pick, k;
        pick = $urandom_range(0, 99);
        if (pick < 25)      cmd = CMD_WR_POINT;
        else if (pick < 50) cmd = CMD_RD_ACTIVE;
        else if (pick < 63) cmd = CMD_RD_POINT;
        else if (pick < 78) cmd = CMD_UPD_TEMP;
        else if (pick < 88) cmd = CMD_FORCE_TEMP;
        else if (pick < 94) cmd = CMD_CLR_DIRTY;
        else if (pick < 97) cmd = CMD_SPARE_6;
        else                cmd = CMD_SPARE_7;
        k = $urandom_range(0, TEMP_POINTS - 1);
        case ($urandom_range(0, 5))
            0, 1: temp = 16'(pt[k] + int'($urandom_range(0, 600)) - 300);
            // land on the hysteresis boundary
            2: temp = 16'(act_temp + ($urandom_range(0, 1) ? hyst : -hyst)
                          + int'($urandom_range(0, 2)) - 1);
            3: temp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: temp = 16'($urandom);
        endcase
        ti  = ($urandom_range(0, 6) == 0) ? 2'd3 : 2'($urandom_range(0, TEMP_POINTS - 1));
        tbl = 2'($urandom);
        soc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(SOC_POINTS, 15))
                                          : 4'($urandom_range(0, SOC_POINTS - 1));
        case ($urandom_range(0, 7))
            0: wv = 16'h0000;
            1: wv = 16'hFFFF;
            default: wv = 16'($urandom);
        endcase
        send_command(cmd, temp, ti, tbl, soc, wv);
    endtask

    // Hold off the sender until every word is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] addr, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == REG_HYST) begin
            hyst = data[14:0];
        end else begin
            pt[addr] = $signed(data);
            derive_weight();
        end
        cfg_count++;
        // a point write reruns the weight divider
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] low, input logic [15:0] mid,
                             input logic [15:0] high, input logic [15:0] hy);
        drain();
        set_register(REG_HYST, hy);
        set_register(REG_PT_LOW, low);
        set_register(REG_PT_MID, mid);
        set_register(REG_PT_HIGH, high);
        repeat (PHASE_ITEMS) random_command();
    endtask

    task automatic test_directed();
        // empty store reads zero
        send_command(CMD_RD_POINT, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd3, 4'd10, 16'd0);
        send_command(CMD_WR_POINT, 16'd0, 2'd0, 2'd0, 4'd0, 16'h1234);
        send_command(CMD_WR_POINT, 16'd0, 2'd1, 2'd0, 4'd0, 16'hFFFF);
        send_command(CMD_WR_POINT, 16'd0, 2'd2, 2'd0, 4'd0, 16'h0000);
        send_command(CMD_WR_POINT, 16'd0, 2'd2, 2'd3, 4'd10, 16'hFFFF);
        // out-of-range writes are dropped
        send_command(CMD_WR_POINT, 16'd0, 2'd3, 2'd1, 4'd2, 16'hAAAA);
        send_command(CMD_WR_POINT, 16'd0, 2'd1, 2'd1, 4'd15, 16'h5555);
        send_command(CMD_WR_POINT, 16'd0, 2'd1, 2'd2, 4'd11, 16'h5555);
        send_command(CMD_RD_POINT, 16'd0, 2'd3, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_POINT, 16'd0, 2'd0, 2'd0, 4'd15, 16'd0);
        send_command(CMD_RD_POINT, 16'd0, 2'd2, 2'd3, 4'd10, 16'd0);
        // active read ignores temp_index
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd3, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd0, 4'd11, 16'd0);
        // below, then exactly at, the hysteresis
        send_command(CMD_UPD_TEMP, 16'd260, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_UPD_TEMP, 16'd230, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_FORCE_TEMP, 16'd150, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        // falling segment exercises the negative floor
        send_command(CMD_FORCE_TEMP, 16'd351, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_FORCE_TEMP, 16'h7FFF, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_FORCE_TEMP, 16'h8000, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_RD_ACTIVE, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_FORCE_TEMP, 16'h8000, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_CLR_DIRTY, 16'd0, 2'd0, 2'd0, 4'd0, 16'd0);
        send_command(CMD_SPARE_6, 16'($urandom), 2'($urandom), 2'($urandom),
                     4'($urandom), 16'($urandom));
        send_command(CMD_SPARE_7, 16'($urandom), 2'($urandom), 2'($urandom),
                     4'($urandom), 16'($urandom));
    endtask

    task automatic test_typical_points();
        run_phase(-16'sd200, 16'sd0, 16'sd400, 16'd5);
    endtask

    task automatic test_extreme_points();
        run_phase(16'h8000, 16'h0000, 16'h7FFF, 16'd0);
    endtask

    task automatic test_equal_points();
        // hysteresis at its maximum; bit 15 of the write data is not stored
        run_phase(16'sd100, 16'sd100, 16'sd100, 16'hFFFF);
    endtask

    task automatic test_non_ascending();
        run_phase(16'sd300, -16'sd100, 16'sd200, 16'd1);
        run_phase(16'h7FFF, 16'h8000, 16'h0000, 16'd50);
    endtask

    task automatic test_random_points();
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 400)));
    endtask

    task automatic test_default_points();
        run_phase(RST_PT_LOW, RST_PT_MID, RST_PT_HIGH, 16'(RST_HYST));
    endtask

    // Check each result word and drive the receiver stall pattern
    always @(posedge i_clk) begin : check_result
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.read_value   = m_axis_tdata[15:0];
            got.current_temp = m_axis_tdata[31:16];
            got.flags        = m_axis_tuser;
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with no command pending, actual %0h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("read_value", want.read_value, got.read_value);
                compare_field("current_temp", want.current_temp, got.current_temp);
                compare_field("dirty", want.flags.dirty, got.flags.dirty);
                compare_field("temp_changed", want.flags.temp_changed, got.flags.temp_changed);
                compare_field("index_error", want.flags.index_error, got.flags.index_error);
            end
        end
        if (rx_hold == 0) begin
            rx_hold    = $urandom_range(50, 300);
            rx_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end else begin
            rx_hold--;
        end
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        m_axis_tready <= rx_pattern[0];
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the weight derivation pass after reset
        repeat (2) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        test_directed();
        test_typical_points();
        test_extreme_points();
        test_equal_points();
        test_non_ascending();
        test_random_points();
        test_default_points();
        drain();

        $display("%0d commands sent, %0d result words compared, %0d register writes",
                 sent_count, result_count, cfg_count);
        $display("covered reset defaults, extreme, equal, reversed and random point sets");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
